### sv/nfst_pkg.sv
// Shared types and constants of the next-fit slot table.
// Used by nfst_cell, next_fit_slot_table_top and the testbench; depends on nothing.
package nfst_pkg;

  localparam int NFST_SLOTS = 16;

  localparam int NAME_W   = 64;
  localparam int PRI_W    = 8;
  localparam int CPU_W    = 16;
  localparam int ID_W     = 8;
  localparam int PID_W    = 9;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;

  // stream payload widths, padded to whole bytes
  localparam int S_DATA_W = 96;
  localparam int M_DATA_W = 104;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_FIND   = 2'd2,
    KIND_RSVD   = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH
  } state_t;

  // broadcast controls from the sequencer to every cell
  typedef struct packed {
    logic load;  // place the search token at the picked cell
    logic run;   // advance the token one cell, claim a free cell under it
    logic drop;  // free the picked cell
  } cell_ctl_t;

endpackage

### sv/next_fit_slot_table_top.sv
// Top level of the next-fit slot table: sequencer, ring of slot cells, result register.
// Depends on nfst_pkg and nfst_cell.
//
//  channel | dir | handshake          | tuser        | tdata (lowest bit up)
//  --------+-----+--------------------+--------------+------------------------------------
//  s_      | in  | s_tvalid/s_tready  | kind [1:0]   | slot_id, name_word, priority_req,
//          |     |                    |              | cpu_needed
//  m_      | out | m_tvalid/m_tready  | status [1:0] | process_id, found_name,
//          |     |                    |              | found_priority, found_cpu, zero pad
//
//  Remove, find and reserved kinds are resolved in S_EXEC; an add places the search token
//  there and goes on to S_SEARCH, where the token visits the ring of cells (one cell per
//  cycle while the output is free) until it hits a free slot or has seen all SLOTS cells.
//  One item is worked at a time; the next item is taken once the current result
//  sits in the output register, even while that result waits for m_tready.
//  Reset clears the used flags, the token ring, last_slot (to SLOTS-1) and m_tvalid
//  and returns the sequencer to S_IDLE; stored entries are not cleared.
//  A stalled output freezes the search and the final table update.
module next_fit_slot_table_top #(
  parameter int SLOTS = nfst_pkg::NFST_SLOTS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // slot_id[7:0], name_word[71:8], priority_req[79:72], cpu_needed[95:80]
  input  logic [nfst_pkg::S_DATA_W-1:0]   s_tdata,
  // kind[1:0]
  input  logic [nfst_pkg::KIND_W-1:0]     s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // process_id[8:0], found_name[72:9], found_priority[80:73], found_cpu[96:81]
  output logic [nfst_pkg::M_DATA_W-1:0]   m_tdata,
  // status[1:0]
  output logic [nfst_pkg::STATUS_W-1:0]   m_tuser
);
  import nfst_pkg::*;

  localparam int IW = $clog2(SLOTS);

  // ---------------------------------------------------------------- item latch
  kind_t             kind;
  logic [ID_W-1:0]   slot_id;
  logic [NAME_W-1:0] name_word;
  logic [PRI_W-1:0]  priority_req;
  logic [CPU_W-1:0]  cpu_needed;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      kind         <= kind_t'(s_tuser);
      slot_id      <= s_tdata[7:0];
      name_word    <= s_tdata[71:8];
      priority_req <= s_tdata[79:72];
      cpu_needed   <= s_tdata[95:80];
    end
  end

  // ---------------------------------------------------------------- cell ring
  cell_ctl_t         ctl;
  logic [SLOTS-1:0]  pick;
  logic [SLOTS-1:0]  tok;
  logic [SLOTS-1:0]  claim;
  logic [SLOTS-1:0]  used;
  logic [NAME_W-1:0] cell_name [SLOTS];
  logic [PRI_W-1:0]  cell_pri  [SLOTS];
  logic [CPU_W-1:0]  cell_cpu  [SLOTS];

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    nfst_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .pick    (pick[i]),
      .tok_in  (tok[(i == 0) ? SLOTS - 1 : i - 1]),
      .wr_name (name_word),
      .wr_pri  (priority_req),
      .wr_cpu  (cpu_needed),
      .tok     (tok[i]),
      .claim   (claim[i]),
      .used    (used[i]),
      .name    (cell_name[i]),
      .pri     (cell_pri[i]),
      .cpu     (cell_cpu[i])
    );
  end

  // ---------------------------------------------------------------- addressing
  logic [IW-1:0] last_slot;
  logic [IW-1:0] start_idx;
  logic [IW-1:0] tgt_idx;
  logic [ID_W-1:0] id_m1;
  logic          in_range;
  logic [IW-1:0] step;
  logic [IW-1:0] hit_idx;
  logic          hit;
  logic          tok_load;

  // search starts one past the last allocation, wrapping at the end
  assign start_idx = (last_slot == IW'(SLOTS - 1)) ? '0 : last_slot + 1'b1;
  assign id_m1     = slot_id - 1'b1;
  assign tgt_idx   = id_m1[IW-1:0];
  assign in_range  = (slot_id != '0) && ({1'b0, slot_id} <= (ID_W + 1)'(SLOTS));
  assign hit       = |claim;
  // an add places the token this cycle
  assign tok_load  = (state == S_EXEC) && (kind == KIND_ADD);

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      pick[i] = tok_load ? (start_idx == IW'(i)) : (in_range && (tgt_idx == IW'(i)));
    end
  end

  // encode the claiming cell, at most one
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      hit_idx = hit_idx | (IW'(i) & {IW{claim[i]}});
    end
  end

  // read the targeted cell through a one-hot OR select
  logic              sel_used;
  logic [NAME_W-1:0] sel_name;
  logic [PRI_W-1:0]  sel_pri;
  logic [CPU_W-1:0]  sel_cpu;

  always_comb begin
    sel_used = 1'b0;
    sel_name = '0;
    sel_pri  = '0;
    sel_cpu  = '0;
    for (int i = 0; i < SLOTS; i++) begin
      sel_used = sel_used | (pick[i] & used[i]);
      sel_name = sel_name | (cell_name[i] & {NAME_W{pick[i]}});
      sel_pri  = sel_pri  | (cell_pri[i]  & {PRI_W{pick[i]}});
      sel_cpu  = sel_cpu  | (cell_cpu[i]  & {CPU_W{pick[i]}});
    end
  end

  // ---------------------------------------------------------------- sequencer
  logic out_free;
  logic res_load;
  status_t           res_status;
  logic [PID_W-1:0]  res_pid;
  logic [NAME_W-1:0] res_name;
  logic [PRI_W-1:0]  res_pri;
  logic [CPU_W-1:0]  res_cpu;
  logic              search_done;

  assign out_free    = ~m_tvalid | m_tready;
  assign search_done = hit || (step == IW'(SLOTS - 1));

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (kind == KIND_ADD) state_next = S_SEARCH;
        else if (out_free)    state_next = S_IDLE;
      end
      S_SEARCH: begin
        if (out_free && search_done) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // cell controls: place the token, advance it, or free the picked cell
  always_comb begin
    ctl = '0;
    case (state)
      S_EXEC: begin
        if (kind == KIND_ADD) begin
          ctl.load = 1'b1;
        end else if (out_free && kind == KIND_REMOVE && in_range && sel_used) begin
          ctl.drop = 1'b1;
        end
      end
      S_SEARCH: begin
        ctl.run = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    res_load   = 1'b0;
    res_status = ST_OK;
    res_pid    = '0;
    res_name   = '0;
    res_pri    = '0;
    res_cpu    = '0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
      end
      S_EXEC: begin
        if (kind != KIND_ADD && out_free) begin
          res_load = 1'b1;
          if (kind == KIND_RSVD || !in_range) begin
            res_status = ST_RANGE;
          end else if (!sel_used) begin
            res_status = ST_EMPTY;
          end else begin
            res_pid = PID_W'(slot_id);
            if (kind == KIND_FIND) begin
              res_name = sel_name;
              res_pri  = sel_pri;
              res_cpu  = sel_cpu;
            end
          end
        end
      end
      S_SEARCH: begin
        if (out_free && search_done) begin
          res_load = 1'b1;
          if (hit) begin
            res_pid = PID_W'(hit_idx) + 1'b1;
          end else begin
            res_status = ST_FULL;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      last_slot <= IW'(SLOTS - 1);
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      if (hit) last_slot <= hit_idx;
      if (res_load)      m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // count visited cells; restart with each new token
  always_ff @(posedge clk) begin
    if (ctl.load)     step <= '0;
    else if (ctl.run) step <= step + 1'b1;
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (res_load) begin
      m_tuser <= res_status;
      m_tdata <= {(M_DATA_W - PID_W - NAME_W - PRI_W - CPU_W)'(0),
                  res_cpu, res_pri, res_name, res_pid};
    end
  end

  // ---------------------------------------------------------------- checks
  a_claim_onehot: assert property (@(posedge clk) disable iff (rst) $onehot0(claim))
    else $error("more than one cell claimed a slot");

  a_token_onehot: assert property (@(posedge clk) disable iff (rst)
    state == S_SEARCH |-> $onehot(tok))
    else $error("search token lost or duplicated");

  a_full_really_full: assert property (@(posedge clk) disable iff (rst)
    res_load && res_status == ST_FULL |-> &used)
    else $error("table reported full with a free slot");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while one is in work");

endmodule

### sv/nfst_cell.sv
// One slot of the next-fit table: used flag, stored entry and the search token stage.
// Depends on nfst_pkg.
module nfst_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  nfst_pkg::cell_ctl_t       ctl,
  input  logic                      pick,
  input  logic                      tok_in,
  input  logic [nfst_pkg::NAME_W-1:0] wr_name,
  input  logic [nfst_pkg::PRI_W-1:0]  wr_pri,
  input  logic [nfst_pkg::CPU_W-1:0]  wr_cpu,
  output logic                      tok,
  output logic                      claim,
  output logic                      used,
  output logic [nfst_pkg::NAME_W-1:0] name,
  output logic [nfst_pkg::PRI_W-1:0]  pri,
  output logic [nfst_pkg::CPU_W-1:0]  cpu
);
  import nfst_pkg::*;

  // token sits here and the slot is free
  assign claim = ctl.run & tok & ~used;

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
      tok  <= 1'b0;
    end else begin
      if (claim) begin
        used <= 1'b1;
      end else if (ctl.drop && pick) begin
        used <= 1'b0;
      end
      if (ctl.load) begin
        tok <= pick;
      end else if (ctl.run) begin
        tok <= tok_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (claim) begin
      name <= wr_name;
      pri  <= wr_pri;
      cpu  <= wr_cpu;
    end
  end

endmodule

### tb/next_fit_slot_table_top_tb.sv
// Self-checking testbench for next_fit_slot_table_top: add, remove and find items
// are checked against an in-bench model of the slot table.
// Depends on nfst_pkg and the RTL of next_fit_slot_table_top.
module next_fit_slot_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nfst_pkg::*;

  localparam int RANDOM_OPS  = 450;
  localparam int CALM_TAIL   = 40;    // last items run with no idling at all
  localparam int LONG_HOLD   = 300;   // cycles the receiver refuses results once
  localparam int HOLD_AT     = 120;   // result count that triggers the long hold
  localparam int SETTLE      = 2 * (NFST_SLOTS + 2);
  localparam int STALL_LIMIT = 2000;

  // one table operation as it goes onto the input stream
  typedef struct packed {
    kind_t              kind;
    logic [ID_W-1:0]    id;
    logic [NAME_W-1:0]  name;
    logic [PRI_W-1:0]   pri;
    logic [CPU_W-1:0]   cpu;
    logic               drain_first;  // hold this item until every reply is back
  } table_op_t;

  // one reply as it comes off the output stream
  typedef struct packed {
    status_t            status;
    logic [PID_W-1:0]   pid;
    logic [NAME_W-1:0]  name;
    logic [PRI_W-1:0]   pri;
    logic [CPU_W-1:0]   cpu;
  } table_reply_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic [KIND_W-1:0]   s_tuser = KIND_ADD;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0] m_tuser;

  next_fit_slot_table_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Shadow copy of the slot table, advanced once per accepted item.
  logic              in_use      [NFST_SLOTS];
  logic [NAME_W-1:0] stored_name [NFST_SLOTS];
  logic [PRI_W-1:0]  stored_pri  [NFST_SLOTS];
  logic [CPU_W-1:0]  stored_cpu  [NFST_SLOTS];
  int                last_used;

  table_op_t    op_queue[$];     // items not yet put on the input stream
  table_reply_t due_replies[$];  // predicted replies, oldest first
  table_op_t    cur_op;          // item currently offered on s_
  int           total_items;
  int           n_accepted = 0;  // items taken by the block (nonblocking)
  int           n_checked = 0;   // replies taken from the block (nonblocking)
  int           n_fail = 0;
  int           tx_gap = 0;
  int           rx_gap = 0;
  int           rx_hold = 0;
  logic         hold_done = 1'b0;
  int           cycle_no = 0;
  int           stall_cycles = 0;

  // Apply one operation to the shadow table and return the reply it earns.
  function automatic table_reply_t apply_to_table(table_op_t op);
    table_reply_t r;
    int slot;
    r = '0;
    if (op.kind == KIND_ADD) begin
      // next-fit: start after the last allocation, wrap, visit last_used last
      r.status = ST_FULL;
      slot = (last_used + 1) % NFST_SLOTS;
      for (int k = 0; k < NFST_SLOTS; k++) begin
        if (!in_use[slot]) begin
          in_use[slot]      = 1'b1;
          stored_name[slot] = op.name;
          stored_pri[slot]  = op.pri;
          stored_cpu[slot]  = op.cpu;
          last_used         = slot;
          r.status          = ST_OK;
          r.pid             = PID_W'(slot + 1);
          return r;
        end
        slot = (slot + 1) % NFST_SLOTS;
      end
      return r;
    end
    // reserved kind and ids outside 1..SLOTS share the range status
    if (op.kind == KIND_RSVD || op.id == 0 || op.id > NFST_SLOTS) begin
      r.status = ST_RANGE;
      return r;
    end
    slot = op.id - 1;
    if (!in_use[slot]) begin
      r.status = ST_EMPTY;
      return r;
    end
    r.status = ST_OK;
    r.pid    = PID_W'(op.id);
    if (op.kind == KIND_REMOVE) begin
      in_use[slot]      = 1'b0;
      stored_name[slot] = '0;
      stored_pri[slot]  = '0;
      stored_cpu[slot]  = '0;
    end else begin
      r.name = stored_name[slot];
      r.pri  = stored_pri[slot];
      r.cpu  = stored_cpu[slot];
    end
    return r;
  endfunction

  task automatic queue_op(kind_t kind, logic [ID_W-1:0] id, logic [NAME_W-1:0] name,
                          logic [PRI_W-1:0] pri, logic [CPU_W-1:0] cpu,
                          logic drain_first);
    table_op_t op;
    op.kind        = kind;
    op.id          = id;
    op.name        = name;
    op.pri         = pri;
    op.cpu         = cpu;
    op.drain_first = drain_first;
    op_queue.push_back(op);
  endtask

  function automatic logic [NAME_W-1:0] any_name();
    return {$urandom, $urandom};
  endfunction

  task automatic check_field(string field, logic [NAME_W-1:0] want,
                             logic [NAME_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", field, want, got);
      n_fail++;
    end
  endtask

  // Stimulus: directed corners first, then random mixes in moods of 50 items.
  initial begin : stimulus
    int mood;
    int pick;
    int add_pct;
    kind_t kind;
    logic [ID_W-1:0] id;

    // empty table: find and remove of free slots, ids out of range, reserved kind
    queue_op(KIND_FIND,   8'd1,   any_name(), 8'd7, 16'd9, 1'b0);
    queue_op(KIND_REMOVE, 8'd16,  any_name(), 8'd7, 16'd9, 1'b0);
    queue_op(KIND_FIND,   8'd0,   any_name(), 8'd7, 16'd9, 1'b0);
    queue_op(KIND_REMOVE, 8'd17,  any_name(), 8'd7, 16'd9, 1'b0);
    queue_op(KIND_FIND,   8'd255, any_name(), 8'd7, 16'd9, 1'b0);
    queue_op(KIND_RSVD,   8'd1,   any_name(), 8'd7, 16'd9, 1'b0);
    // field extremes stored and read back
    queue_op(KIND_ADD,  8'd0,   '0, 8'h00, 16'h0000, 1'b0);
    queue_op(KIND_ADD,  8'd255, '1, 8'hff, 16'hffff, 1'b0);
    queue_op(KIND_FIND, 8'd1,   '0, 8'h00, 16'h0000, 1'b0);
    queue_op(KIND_FIND, 8'd2,   '0, 8'h00, 16'h0000, 1'b0);
    // remove, then remove the now free slot again
    queue_op(KIND_REMOVE, 8'd1, '0, 8'h00, 16'h0000, 1'b0);
    queue_op(KIND_REMOVE, 8'd1, '0, 8'h00, 16'h0000, 1'b0);
    // fill the table, wrapping back to slot one, then overflow it
    for (int n = 0; n < NFST_SLOTS; n++)
      queue_op(KIND_ADD, 8'($urandom), any_name(), 8'($urandom), 16'($urandom), 1'b0);

    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 50 == 0) mood = $urandom_range(0, 2);
      add_pct = (mood == 0) ? 70 : (mood == 1) ? 25 : 45;
      pick = $urandom_range(0, 99);
      if (pick < add_pct) kind = KIND_ADD;
      else if (pick < 97) kind = $urandom_range(0, 1) ? KIND_REMOVE : KIND_FIND;
      else kind = KIND_RSVD;
      if (kind == KIND_ADD || kind == KIND_RSVD) id = 8'($urandom);
      else if ($urandom_range(0, 9) == 0)
        id = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(NFST_SLOTS + 1, 255));
      else id = 8'($urandom_range(1, NFST_SLOTS));
      queue_op(kind, id, any_name(), 8'($urandom), 16'($urandom), n % 150 == 75);
    end
    total_items = op_queue.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // wait for every item to go in and every reply to come out, then settle
    do @(posedge clk);
    while (n_accepted != total_items || n_checked != total_items);
    repeat (SETTLE) @(posedge clk);
    if (due_replies.size() != 0) begin
      $error("%0d predicted replies never arrived", due_replies.size());
      n_fail++;
    end
    if (n_fail == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Driver: offer queued items, predict the reply of each accepted one.
  always @(posedge clk) begin : driver
    logic took;
    logic drained;
    if (rst) begin
      s_tvalid  <= 1'b0;
      tx_gap    <= 0;
      in_use    = '{default: 1'b0};
      last_used = NFST_SLOTS - 1;
    end else begin
      took = s_tvalid && s_tready;
      if (took) begin
        due_replies.push_back(apply_to_table(cur_op));
        n_accepted <= n_accepted + 1;
      end
      // counters are read before this edge's updates, so this is order-safe
      drained = !took && n_accepted == n_checked;
      if (!s_tvalid || s_tready) begin
        if (tx_gap != 0) begin
          tx_gap   <= tx_gap - 1;
          s_tvalid <= 1'b0;
        end else if (op_queue.size() != 0 && (!op_queue[0].drain_first || drained)) begin
          cur_op   = op_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {cur_op.cpu, cur_op.pri, cur_op.name, cur_op.id};
          s_tuser  <= cur_op.kind;
          // idle bursts only while bit 6 of cycle_no is set and not in the tail
          if (op_queue.size() > CALM_TAIL && cycle_no[6] && $urandom_range(0, 3) == 0)
            tx_gap <= $urandom_range(1, 14);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: take replies, compare against the oldest prediction, pace m_tready.
  always @(posedge clk) begin : monitor
    table_reply_t got;
    table_reply_t want;
    if (rst) begin
      m_tready <= 1'b0;
      rx_gap   <= 0;
      rx_hold  <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.status = status_t'(m_tuser);
        got.pid    = m_tdata[8:0];
        got.name   = m_tdata[72:9];
        got.pri    = m_tdata[80:73];
        got.cpu    = m_tdata[96:81];
        if (due_replies.size() == 0) begin
          $error("reply with nothing predicted: status %0d id %0d", got.status, got.pid);
          n_fail++;
        end else begin
          want = due_replies.pop_front();
          check_field("status",         want.status, got.status);
          check_field("process_id",     want.pid,    got.pid);
          check_field("found_name",     want.name,   got.name);
          check_field("found_priority", want.pri,    got.pri);
          check_field("found_cpu",      want.cpu,    got.cpu);
        end
        n_checked <= n_checked + 1;
      end
      // once in the run: refuse replies long enough for the input to back up
      if (!hold_done && n_checked >= HOLD_AT) begin
        hold_done <= 1'b1;
        rx_hold   <= LONG_HOLD;
        m_tready  <= 1'b0;
      end else if (rx_hold != 0) begin
        rx_hold  <= rx_hold - 1;
        m_tready <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap   <= rx_gap - 1;
        m_tready <= 1'b0;
      end else if (n_checked < total_items - CALM_TAIL && cycle_no[7] &&
                   $urandom_range(0, 5) == 0) begin
        rx_gap   <= $urandom_range(1, 14) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if neither stream moves for too long.
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

### sim.f
sv/nfst_pkg.sv
sv/nfst_cell.sv
sv/next_fit_slot_table_top.sv
tb/next_fit_slot_table_top_tb.sv
